[hw/rtl/mmd_pkg.sv]
// shared types and constants of the 3x3 mask margin dilation block
// no dependencies; every other file of the block imports this package
package mmd_pkg;

    typedef logic [1:0] t_pix;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam t_pix PIX_EMPTY  = 2'd0;
    localparam t_pix PIX_MARGIN = 2'd1;

    localparam int IMAGE_WIDTH_W  = 12;
    localparam int IMAGE_HEIGHT_W = 13;
    localparam int CFG_DW         = 13;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [IMAGE_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 12'd2048;
    localparam logic [IMAGE_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd1;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // control that travels with one window advance from the raster tracker
    typedef struct packed {
        t_pix d;
        logic emit;
        logic last;
        logic ocol_first;
        logic ocol_last;
        logic orow_first;
        logic orow_last;
    } t_adv_ctl;

endpackage

[hw/rtl/mmd_if.sv]
// valid/ready channel interfaces for the input items and the result items
// depends on mmd_pkg for the pixel type
interface mmd_in_if import mmd_pkg::*; ();
    logic valid;
    logic ready;
    logic req_type;
    t_pix pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

interface mmd_out_if import mmd_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel_out;
    logic frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

[hw/rtl/mmd_raster.sv]
// raster position tracker: config registers, input position, issue of window advances
// depends on mmd_pkg
module mmd_raster import mmd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_data,
    input  logic                 i_valid,
    input  logic                 i_req_type,
    input  t_pix                 i_pixel,
    output logic                 o_ready,
    input  logic                 i_s1_take,
    output logic                 o_issue,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output t_adv_ctl             o_ctl
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    function automatic logic [WW-1:0] sat_width(input logic [IMAGE_WIDTH_W-1:0] v);
        logic [WW-1:0] res;
        if (v == '0) begin
            res = WW'(1);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            res = WW'(MAX_WIDTH);
        end else begin
            res = WW'(v);
        end
        return res;
    endfunction

    function automatic logic [HW-1:0] sat_height(input logic [IMAGE_HEIGHT_W-1:0] v);
        logic [HW-1:0] res;
        if (v == '0) begin
            res = HW'(1);
        end else if (32'(v) > 32'(MAX_HEIGHT)) begin
            res = HW'(MAX_HEIGHT);
        end else begin
            res = HW'(v);
        end
        return res;
    endfunction

    logic [WW-1:0] r_width,  n_width;
    logic [HW-1:0] r_height, n_height;
    logic [CW-1:0] r_col,    n_col;
    logic [RW-1:0] r_row,    n_row;
    logic          r_extra,  n_extra;

    logic          accepted;
    logic          in_rows;
    logic          adv;
    logic          col_is0;
    logic          col_last;
    logic          row_is1;
    logic          width_one;
    logic [RW-1:0] h_ext;
    logic [RW-1:0] h_plus1;
    t_adv_ctl      ctl;

    assign o_ready  = i_s1_take && !r_extra;
    assign accepted = i_valid && o_ready;

    assign h_ext     = RW'(r_height);
    assign h_plus1   = h_ext + RW'(1);
    assign in_rows   = r_row < h_ext;
    assign col_is0   = (r_col == '0);
    assign col_last  = (WW'(r_col) == r_width - WW'(1));
    assign row_is1   = (r_row == RW'(1));
    assign width_one = (r_width == WW'(1));

    // pixel items advance only inside the frame, flush items only after its last pixel
    always_comb begin
        if (r_extra) begin
            adv = i_s1_take;
        end else if (i_req_type == REQ_PIXEL) begin
            adv = accepted && in_rows;
        end else begin
            adv = accepted && !in_rows;
        end
    end

    always_comb begin
        ctl.d          = (r_extra || i_req_type == REQ_FLUSH) ? PIX_EMPTY : i_pixel;
        ctl.emit       = (r_row >= RW'(2)) || (row_is1 && !col_is0);
        ctl.last       = (r_row == h_plus1) && col_is0;
        ctl.ocol_first = width_one || (r_col == CW'(1));
        ctl.ocol_last  = width_one || col_is0;
        // the output pixel trails by one row plus one pixel
        ctl.orow_first = col_is0 ? (r_row == RW'(2)) : row_is1;
        ctl.orow_last  = col_is0 ? (r_row >= h_plus1) : (r_row >= h_ext);
    end

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_extra  = r_extra;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH: begin
                    n_width = sat_width(i_cfg_data[IMAGE_WIDTH_W-1:0]);
                end
                CFG_IMAGE_HEIGHT: begin
                    n_height = sat_height(i_cfg_data[IMAGE_HEIGHT_W-1:0]);
                end
                default: begin
                end
            endcase
            n_col   = '0;
            n_row   = '0;
            n_extra = 1'b0;
        end else if (adv) begin
            if (ctl.emit && ctl.last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_last) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
            // a flush landing one pixel short of the first result needs a second advance
            n_extra = !r_extra && (i_req_type == REQ_FLUSH) && !ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sat_width(RST_IMAGE_WIDTH);
            r_height <= sat_height(RST_IMAGE_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
            r_extra  <= 1'b0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_extra  <= n_extra;
        end
    end

    assign o_issue = adv;
    assign o_col   = r_col;
    assign o_ctl   = ctl;

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_plus1)
        else $error("input row ran past the drain row");

    a_extra_one_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extra |-> (r_height == HW'(1)))
        else $error("second flush advance outside a one-row frame");

    a_extra_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_extra |-> !accepted)
        else $error("item accepted during a second flush advance");

endmodule

[hw/rtl/mmd_line_store.sv]
// two line stores holding the rows above the input position, registered read
// depends on mmd_pkg; a write to the address being read is forwarded
module mmd_line_store import mmd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  t_pix                         i_wr_upper,
    input  t_pix                         i_wr_middle,
    output t_pix                         o_rd_upper,
    output t_pix                         o_rd_middle
);

    t_pix r_upper  [MAX_WIDTH];
    t_pix r_middle [MAX_WIDTH];
    t_pix r_rd_upper;
    t_pix r_rd_middle;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper[i_wr_addr]  <= i_wr_upper;
            r_middle[i_wr_addr] <= i_wr_middle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && i_wr_addr == i_rd_addr) begin
                r_rd_upper  <= i_wr_upper;
                r_rd_middle <= i_wr_middle;
            end else begin
                r_rd_upper  <= r_upper[i_rd_addr];
                r_rd_middle <= r_middle[i_rd_addr];
            end
        end
    end

    assign o_rd_upper  = r_rd_upper;
    assign o_rd_middle = r_rd_middle;

endmodule

[hw/rtl/mmd_window.sv]
// advance stage, 3x3 window registers, dilation and result register
// depends on mmd_pkg; drives the line store writes
module mmd_window import mmd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_issue,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_issue_col,
    input  t_adv_ctl                     i_issue_ctl,
    output logic                         o_s1_take,
    input  t_pix                         i_rd_upper,
    input  t_pix                         i_rd_middle,
    output logic                         o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0] o_wr_addr,
    output t_pix                         o_wr_upper,
    output t_pix                         o_wr_middle,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output t_pix                         o_pixel_out,
    output logic                         o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic            r_s1_valid, n_s1_valid;
    logic [CW-1:0]   r_s1_col;
    t_adv_ctl        r_s1_ctl;
    logic [2:0][1:0] r_w1;
    logic [2:0][1:0] r_w2;
    logic            r_out_valid, n_out_valid;
    t_pix            r_pixel_out;
    logic            r_frame_last;

    logic            s1_go;
    logic [2:0][1:0] col2;
    logic [2:0][1:0] lcol;
    logic [2:0][1:0] rcol;
    logic [1:0]      top_row;
    logic [1:0]      bot_row;
    logic            any_set;
    t_pix            result;

    // a record that yields no result never waits on the result register
    assign s1_go     = r_s1_valid && (!r_s1_ctl.emit || !r_out_valid || i_out_ready);
    assign o_s1_take = !r_s1_valid || s1_go;

    // new column: upper row, middle row, incoming pixel; index 0 is the top
    assign col2 = {r_s1_ctl.d, i_rd_middle, i_rd_upper};

    // centre sits in r_w2; clamped neighbours fall back on the centre column or row
    always_comb begin
        top_row = r_s1_ctl.orow_first ? 2'd1 : 2'd0;
        bot_row = r_s1_ctl.orow_last  ? 2'd1 : 2'd2;
        lcol    = r_s1_ctl.ocol_first ? r_w2 : r_w1;
        rcol    = r_s1_ctl.ocol_last  ? r_w2 : col2;
        any_set = |{lcol[top_row], r_w2[top_row], rcol[top_row],
                    lcol[1], rcol[1],
                    lcol[bot_row], r_w2[bot_row], rcol[bot_row]};
        if (r_w2[1] != PIX_EMPTY) begin
            result = r_w2[1];
        end else begin
            result = any_set ? PIX_MARGIN : PIX_EMPTY;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_issue) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_go && r_s1_ctl.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s1_col <= i_issue_col;
            r_s1_ctl <= i_issue_ctl;
        end
        if (s1_go) begin
            r_w1 <= r_w2;
            r_w2 <= col2;
        end
        if (s1_go && r_s1_ctl.emit) begin
            r_pixel_out  <= result;
            r_frame_last <= r_s1_ctl.last;
        end
    end

    // the upper store takes the old middle row, the middle store the new pixel
    assign o_wr_en     = s1_go;
    assign o_wr_addr   = r_s1_col;
    assign o_wr_upper  = i_rd_middle;
    assign o_wr_middle = r_s1_ctl.d;

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pixel_out;
    assign o_frame_last = r_frame_last;

    a_issue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_issue |-> o_s1_take)
        else $error("advance issued while the stage is held");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_ctl.emit && r_out_valid && !i_out_ready)
        |=> (r_s1_valid && $stable(r_s1_col) && $stable(r_w2)))
        else $error("pending result record lost while output stalled");

endmodule

[hw/rtl/mask_margin_dilation_3x3_core.sv]
// top level of the 3x3 mask margin dilation block
// depends on mmd_pkg, mmd_if, mmd_raster, mmd_line_store, mmd_window
//
//  port        dir  kind        contents
//  i_pix       in   valid/ready req_type, pixel_in
//  o_res       out  valid/ready pixel_out, frame_last
//  i_cfg_*     in   write port  image_width (index 0), image_height (index 1)
//
// one item per cycle while ready is high; a result is held in the advance stage register,
// then in the result register; results trail the input by one row plus one pixel
// (flush items drain the tail); a flush that meets the end of the first row of a one-row
// frame issues two window advances in turn, as they share the single line store read port
// synchronous active-low reset clears positions and control; line stores are not cleared
// when the result register is held, one more item that yields a result enters the
// advance stage, then ready drops
module mask_margin_dilation_3x3_core import mmd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mmd_in_if.sink               i_pix,
    mmd_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic          s1_take;
    logic          issue;
    logic [CW-1:0] issue_col;
    t_adv_ctl      issue_ctl;
    t_pix          rd_upper;
    t_pix          rd_middle;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    t_pix          wr_upper;
    t_pix          wr_middle;

    mmd_raster #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_raster (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_pix.valid),
        .i_req_type (i_pix.req_type),
        .i_pixel    (i_pix.pixel_in),
        .o_ready    (i_pix.ready),
        .i_s1_take  (s1_take),
        .o_issue    (issue),
        .o_col      (issue_col),
        .o_ctl      (issue_ctl)
    );

    mmd_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_rd_en     (issue),
        .i_rd_addr   (issue_col),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_upper  (wr_upper),
        .i_wr_middle (wr_middle),
        .o_rd_upper  (rd_upper),
        .o_rd_middle (rd_middle)
    );

    mmd_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_issue      (issue),
        .i_issue_col  (issue_col),
        .i_issue_ctl  (issue_ctl),
        .o_s1_take    (s1_take),
        .i_rd_upper   (rd_upper),
        .i_rd_middle  (rd_middle),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_upper   (wr_upper),
        .o_wr_middle  (wr_middle),
        .o_out_valid  (o_res.valid),
        .i_out_ready  (o_res.ready),
        .o_pixel_out  (o_res.pixel_out),
        .o_frame_last (o_res.frame_last)
    );

endmodule

[tb/mask_margin_dilation_3x3_core_test.sv]
// testbench of mask_margin_dilation_3x3_core: directed and random mask frames through the
// pixel channel, each result checked against a dilation predictor kept in this file
// depends on mmd_pkg, mmd_if and the rtl of the block
`timescale 1ns / 1ps

module mask_margin_dilation_3x3_core_test import mmd_pkg::*; ();

    localparam t_pix PIX_BAKED = 2'd2;
    localparam t_pix PIX_ODD   = 2'd3;
    localparam int   SETTLE_CYCLES = 10;
    localparam int   RANDOM_ITEMS  = 260;

    typedef struct {
        t_pix pixel;
        logic last;
    } t_dil_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DW-1:0]    i_cfg_data;

    mmd_in_if  pix_if ();
    mmd_out_if res_if ();

    mask_margin_dilation_3x3_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // dilation predictor state
    bit [1:0]                  upper_row [DEF_MAX_WIDTH];
    bit [1:0]                  middle_row [DEF_MAX_WIDTH];
    bit [1:0]                  win [3][3];
    int unsigned               pred_col;
    int unsigned               pred_row;
    int unsigned               pred_count;
    logic [IMAGE_WIDTH_W-1:0]  width_reg;
    logic [IMAGE_HEIGHT_W-1:0] height_reg;

    t_dil_result dilated_q [$];
    int          mismatch_count;
    int          items_used;
    bit          idling_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (width_reg == '0) return 1;
        if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == '0) return 1;
        if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
        return 32'(height_reg);
    endfunction

    function automatic void frame_restart();
        pred_col = 0;
        pred_row = 0;
        pred_count = 0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) win[r][k] = '0;
        end
    endfunction

    // dilated value of the pixel whose centre sits in window column k
    function automatic t_pix window_value(int unsigned k, int unsigned w, int unsigned h);
        int unsigned orow;
        int unsigned ocol;
        int unsigned top;
        int unsigned bot;
        int unsigned lef;
        int unsigned rig;
        bit [1:0]    any;
        orow = pred_count / w;
        ocol = pred_count % w;
        top = (orow == 0) ? 1 : 0;
        bot = (orow + 1 >= h) ? 1 : 2;
        lef = (ocol == 0 || k == 0) ? k : k - 1;
        rig = (ocol + 1 >= w || k >= 2) ? k : k + 1;
        if (win[1][k] != 0) return win[1][k];
        any = win[top][lef] | win[top][k] | win[top][rig] | win[1][lef] | win[1][rig]
            | win[bot][lef] | win[bot][k] | win[bot][rig];
        return (any != 0) ? PIX_MARGIN : PIX_EMPTY;
    endfunction

    function automatic bit dilate_advance(t_pix d, output t_dil_result res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned pos;
        bit          emit;
        t_pix        val;
        bit [1:0]    a;
        bit [1:0]    b;
        w = eff_width();
        h = eff_height();
        c = pred_col;
        pos = pred_row * w + pred_col;
        emit = (pos >= w + 1) && (pred_count < w * h);
        val = PIX_EMPTY;
        res.pixel = PIX_EMPTY;
        res.last = 1'b0;
        if (c >= DEF_MAX_WIDTH) c = 0;
        a = upper_row[c];
        b = middle_row[c];
        upper_row[c] = b;
        middle_row[c] = d;
        // at column zero the centre is still the newest column of the window
        if (emit && c == 0) val = window_value(2, w, h);
        for (int j = 0; j < 3; j++) begin
            win[j][0] = win[j][1];
            win[j][1] = win[j][2];
        end
        win[0][2] = a;
        win[1][2] = b;
        win[2][2] = d;
        if (emit && c != 0) val = window_value(1, w, h);
        pred_col++;
        if (pred_col >= w) begin
            pred_col = 0;
            pred_row++;
        end
        if (emit) begin
            res.pixel = val;
            res.last = (pred_count + 1 == w * h);
            pred_count++;
            if (res.last) frame_restart();
        end
        return emit;
    endfunction

    // returns 1 when the item moved the raster position
    function automatic bit dilate_accept(logic req, t_pix pix);
        t_dil_result res;
        if (req == REQ_PIXEL) begin
            if (pred_row >= eff_height()) return 0;
            if (dilate_advance(pix, res)) dilated_q.push_back(res);
            return 1;
        end
        if (pred_row < eff_height()) return 0;
        for (int n = 0; n < 2; n++) begin
            if (dilate_advance(PIX_EMPTY, res)) begin
                dilated_q.push_back(res);
                return 1;
            end
        end
        return 1;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // mostly empty, so that dilation shows around sparse set pixels
    function automatic t_pix rand_pix();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return PIX_EMPTY;
        if (r < 8) return PIX_BAKED;
        if (r < 9) return PIX_MARGIN;
        return PIX_ODD;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(logic req, t_pix pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.req_type <= req;
        pix_if.pixel_in <= pix;
        do @(posedge i_clk); while (!pix_if.ready);
        if (dilate_accept(req, pix)) items_used++;
        @(negedge i_clk);
    endtask

    task automatic drain_results(int settle);
        pix_if.valid <= 1'b0;
        while (dilated_q.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = data[IMAGE_WIDTH_W-1:0];
        else height_reg = data[IMAGE_HEIGHT_W-1:0];
        frame_restart();
        @(negedge i_clk);
    endtask

    task automatic set_size(logic [CFG_DW-1:0] w, logic [CFG_DW-1:0] h);
        drain_results(SETTLE_CYCLES);
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
    endtask

    // flush until the frame's last result is predicted, with stray pixels if noisy
    task automatic drain_frame(bit noisy);
        while (pred_row >= eff_height()) begin
            if (noisy && $urandom_range(0, 5) == 0) send_item(REQ_PIXEL, rand_pix());
            else send_item(REQ_FLUSH, t_pix'($urandom_range(0, 3)));
        end
    endtask

    task automatic send_pixels(int unsigned n);
        for (int unsigned i = 0; i < n; i++) send_item(REQ_PIXEL, rand_pix());
    endtask

    task automatic test_reset_sizes();
        // part of a row at the reset width yields nothing; the reset height of one row
        // then holds under a narrow width
        send_pixels(24);
        drain_results(SETTLE_CYCLES);
        cfg_write(CFG_IMAGE_WIDTH, 6);
        send_pixels(6);
        drain_frame(0);
        send_item(REQ_FLUSH, PIX_EMPTY);
    endtask

    task automatic test_directed();
        set_size(3, 3);
        send_item(REQ_FLUSH, PIX_BAKED);
        send_item(REQ_PIXEL, PIX_BAKED);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_EMPTY);
        // flush in mid frame is ignored
        send_item(REQ_FLUSH, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_ODD);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_MARGIN);
        // a pixel during the tail is dropped
        send_item(REQ_FLUSH, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_BAKED);
        drain_frame(0);
        send_item(REQ_FLUSH, PIX_ODD);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_MARGIN);
    endtask

    task automatic test_small_sizes();
        // zero sizes act as one pixel frames
        set_size(0, 0);
        for (int v = 0; v < 4; v++) begin
            send_item(REQ_PIXEL, t_pix'(v));
            send_item(REQ_PIXEL, PIX_ODD);
            drain_frame(0);
            send_item(REQ_FLUSH, PIX_EMPTY);
        end
        set_size(1, 4);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_BAKED);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_EMPTY);
        drain_frame(0);
        set_size(5, 1);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_MARGIN);
        send_item(REQ_PIXEL, PIX_EMPTY);
        send_item(REQ_PIXEL, PIX_EMPTY);
        drain_frame(0);
    endtask

    task automatic test_size_saturation();
        // width above the maximum saturates; upper data bit is not width
        set_size({CFG_DW{1'b1}}, 2);
        send_pixels(30);
        // tallest frame, one pixel wide, left part way
        set_size(0, {CFG_DW{1'b1}});
        send_pixels(30);
    endtask

    task automatic test_random();
        int          start;
        int unsigned kind;
        int unsigned w;
        int unsigned h;
        int          pause_at;
        bit          paused;
        start = items_used;
        paused = 0;
        while (items_used - start < RANDOM_ITEMS) begin
            drain_results(SETTLE_CYCLES);
            w = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            h = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(0, 12);
            if (!paused || $urandom_range(0, 3) != 0) cfg_write(CFG_IMAGE_WIDTH, CFG_DW'(w));
            if (!paused || $urandom_range(0, 3) != 0) cfg_write(CFG_IMAGE_HEIGHT, CFG_DW'(h));
            idling_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                w = eff_width();
                h = eff_height();
                pause_at = (!paused || $urandom_range(0, 3) == 0) ?
                           $urandom_range(0, w * h - 1) : -1;
                for (int i = 0; i < w * h; i++) begin
                    if (i == pause_at) begin
                        drain_results(0);
                        paused = 1;
                    end
                    if ($urandom_range(0, 19) == 0) send_item(REQ_FLUSH, rand_pix());
                    send_item(REQ_PIXEL, rand_pix());
                end
                drain_frame(1);
                repeat ($urandom_range(0, 2)) send_item(REQ_FLUSH, rand_pix());
            end else if (kind < 9) begin
                // frame abandoned part way
                repeat ($urandom_range(0, eff_width() * eff_height() - 1))
                    send_item(($urandom_range(0, 9) == 0) ? REQ_FLUSH : REQ_PIXEL, rand_pix());
            end else begin
                repeat ($urandom_range(5, 20))
                    send_item(logic'($urandom_range(0, 1)), t_pix'($urandom_range(0, 3)));
            end
        end
        idling_on = 1;
    endtask

    initial begin : ready_gen
        int hold;
        hold = 0;
        res_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                hold = pick_gap();
                if (hold > 0) begin
                    res_if.ready <= 1'b0;
                    hold--;
                end else begin
                    res_if.ready <= 1'b1;
                    hold = $urandom_range(0, 6);
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_dil_result expected_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (dilated_q.size() == 0) begin
                $display("%0t: result with none expected: pixel_out %0d frame_last %0d",
                         $time, res_if.pixel_out, res_if.frame_last);
                mismatch_count++;
            end else begin
                expected_res = dilated_q.pop_front();
                if (res_if.pixel_out !== expected_res.pixel) begin
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $time, expected_res.pixel, res_if.pixel_out);
                    mismatch_count++;
                end
                if (res_if.frame_last !== expected_res.last) begin
                    $display("%0t: frame_last expected %0d actual %0d",
                             $time, expected_res.last, res_if.frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.req_type = REQ_PIXEL;
        pix_if.pixel_in = PIX_EMPTY;
        mismatch_count = 0;
        items_used = 0;
        idling_on = 1;
        for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        width_reg = RST_IMAGE_WIDTH;
        height_reg = RST_IMAGE_HEIGHT;
        frame_restart();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_sizes();
        test_directed();
        test_small_sizes();
        test_size_saturation();
        test_random();

        drain_results(2 * SETTLE_CYCLES);
        if (dilated_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, dilated_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mmd_pkg.sv
hw/rtl/mmd_if.sv
hw/rtl/mmd_raster.sv
hw/rtl/mmd_line_store.sv
hw/rtl/mmd_window.sv
hw/rtl/mask_margin_dilation_3x3_core.sv
tb/mask_margin_dilation_3x3_core_test.sv
